>>> rtl/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

  // parameter defaults
  localparam int COORD_BITS_DEF    = 12;
  localparam int CORDIC_STAGES_DEF = 16;

  // datapath widths
  localparam int HW = 34;  // hyperbolic x/y
  localparam int CW = 34;  // circular x/y
  localparam int ZW = 20;  // angle accumulators

  // fixed-point constants
  localparam int LN2_HALF = 22713;
  localparam int LN_TENTH = -150903;
  localparam int PI_Q16   = 205887;
  localparam int ONE_Q16  = 65536;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TIGHT  = 3'd2;
  localparam logic [2:0] REG_REPS   = 3'd3;
  localparam logic [2:0] REG_FIRST  = 3'd4;
  localparam logic [2:0] REG_SECOND = 3'd5;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [47:0] pixel_color;
    logic        takes_first;
  } out_t;

  typedef struct packed {
    logic [12:0]        image_width;
    logic [12:0]        image_height;
    logic signed [15:0] spiral_tightness;
    logic signed [15:0] repetitions;
    logic [47:0]        first_color;
    logic [47:0]        second_color;
  } cfg_t;

  // state handed from cell to cell
  typedef struct packed {
    logic signed [HW-1:0] hx;
    logic signed [HW-1:0] hy;
    logic signed [ZW-1:0] hz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic [4:0]           e;
    logic                 zero;
  } cord_t;

  // hyperbolic shift for iteration k, with repeats at 4 and 13
  function automatic int hyp_shift(input int k);
    int i;
    bit rep;
    i = 1;
    rep = 1'b0;
    for (int j = 0; j < k; j++) begin
      if ((i == 4 || i == 13) && !rep) begin
        rep = 1'b1;
      end else begin
        rep = 1'b0;
        i++;
      end
    end
    return i;
  endfunction

  // atanh(2^-(idx+1)) in q16
  function automatic int atanh_q16(input int idx);
    case (idx)
      0: return 35999;  1: return 16739;  2: return 8235;  3: return 4101;
      4: return 2049;   5: return 1024;   6: return 512;   7: return 256;
      8: return 128;    9: return 64;     10: return 32;   11: return 16;
      12: return 8;     13: return 4;     14: return 2;    15: return 1;
      default: return 0;
    endcase
  endfunction

  // atan(2^-idx)/pi in q16
  function automatic int atan_pi_q16(input int idx);
    case (idx)
      0: return 16384;  1: return 9672;   2: return 5110;  3: return 2594;
      4: return 1302;   5: return 652;    6: return 326;   7: return 163;
      8: return 81;     9: return 41;     10: return 20;   11: return 10;
      12: return 5;     13: return 3;     14: return 1;    15: return 1;
      default: return 0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/dsc_prep.sv
`default_nettype none
module dsc_prep #(
  parameter int COORD_BITS = dsc_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dsc_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dsc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dsc_pkg::cord_t     out_c
);

  localparam int ZW = dsc_pkg::ZW;
  localparam int CW = dsc_pkg::CW;
  localparam int PW = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam logic [11:0] CMASK = 12'((32'd1 << PW) - 32'd1);

  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2;
  logic signed [13:0] dx0_r, dy0_r, dx1_r, dy1_r;
  logic [27:0] sqx_r, sqy_r;
  dsc_pkg::cord_t c_r;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  // centre offsets in half pixels
  logic [11:0] px, py;
  logic signed [13:0] dx_nxt, dy_nxt;
  always_comb begin
    px = in_data.pixel_x & CMASK;
    py = in_data.pixel_y & CMASK;
    dx_nxt = $signed({1'b0, px, 1'b0}) - $signed({1'b0, cfg.image_width});
    dy_nxt = $signed({1'b0, py, 1'b0}) - $signed({1'b0, cfg.image_height});
  end

  // squared radius, normalised mantissa and cordic seeds
  logic [27:0] s;
  logic [4:0]  e;
  logic [29:0] m;
  logic signed [CW-1:0] cx0, cy0;
  dsc_pkg::cord_t c_nxt;
  always_comb begin
    s = sqx_r + sqy_r;
    e = 5'd0;
    for (int b = 0; b < 28; b++) begin
      if (s[b]) e = 5'(b + 1);
    end
    m   = 30'({2'b00, s} << (6'd30 - {1'b0, e}));
    cx0 = {{4{dx1_r[13]}}, dx1_r, 16'b0};
    cy0 = {{4{dy1_r[13]}}, dy1_r, 16'b0};
    c_nxt.hx   = $signed({4'b0, m}) + 34'sh40000000;
    c_nxt.hy   = $signed({4'b0, m}) - 34'sh40000000;
    c_nxt.hz   = '0;
    c_nxt.e    = e;
    c_nxt.zero = (s == 28'd0);
    if (dx1_r < 0) begin
      c_nxt.cx = -cx0;
      c_nxt.cy = -cy0;
      c_nxt.cz = (dy1_r >= 0) ? ZW'(dsc_pkg::ONE_Q16) : ZW'(-dsc_pkg::ONE_Q16);
    end else begin
      c_nxt.cx = cx0;
      c_nxt.cy = cy0;
      c_nxt.cz = '0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      dx0_r <= dx_nxt;
      dy0_r <= dy_nxt;
    end
    if (rdy1 && v0_r) begin
      dx1_r <= dx0_r;
      dy1_r <= dy0_r;
      sqx_r <= 28'(dx0_r * dx0_r);
      sqy_r <= 28'(dy0_r * dy0_r);
    end
    if (rdy2 && v1_r) c_r <= c_nxt;
  end

  assign out_valid = v2_r;
  assign out_c     = c_r;

endmodule
`default_nettype wire

>>> rtl/dsc_cell.sv
`default_nettype none
module dsc_cell #(
  parameter int K = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dsc_pkg::cord_t in_c,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dsc_pkg::cord_t      out_c
);

  localparam int HS = dsc_pkg::hyp_shift(K);
  localparam int ZW = dsc_pkg::ZW;
  localparam logic signed [ZW-1:0] TH = ZW'(dsc_pkg::atanh_q16(HS - 1));
  localparam logic signed [ZW-1:0] TC = ZW'(dsc_pkg::atan_pi_q16(K));

  logic v_r;
  dsc_pkg::cord_t c_r, c_nxt;

  assign in_ready = !v_r || out_ready;

  // one hyperbolic and one circular micro-rotation
  always_comb begin
    c_nxt = in_c;
    if (in_c.hy < 0) begin
      c_nxt.hx = in_c.hx + (in_c.hy >>> HS);
      c_nxt.hy = in_c.hy + (in_c.hx >>> HS);
      c_nxt.hz = in_c.hz - TH;
    end else begin
      c_nxt.hx = in_c.hx - (in_c.hy >>> HS);
      c_nxt.hy = in_c.hy - (in_c.hx >>> HS);
      c_nxt.hz = in_c.hz + TH;
    end
    if (in_c.cy >= 0) begin
      c_nxt.cx = in_c.cx + (in_c.cy >>> K);
      c_nxt.cy = in_c.cy - (in_c.cx >>> K);
      c_nxt.cz = in_c.cz + TC;
    end else begin
      c_nxt.cx = in_c.cx - (in_c.cy >>> K);
      c_nxt.cy = in_c.cy + (in_c.cx >>> K);
      c_nxt.cz = in_c.cz - TC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) c_r <= c_nxt;
  end

  assign out_valid = v_r;
  assign out_c     = c_r;

endmodule
`default_nettype wire

>>> rtl/dsc_post.sv
`default_nettype none
module dsc_post (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dsc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dsc_pkg::cord_t in_c,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dsc_pkg::out_t       out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic signed [21:0] lr1_r, lr2_r;
  logic signed [19:0] a1_r, a2_r;
  logic signed [35:0] ta_r;
  logic signed [30:0] p_r;
  logic signed [47:0] u_r, v_r;
  dsc_pkg::out_t o_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // log radius, centre case and twist product
  logic signed [5:0]  em2;
  logic signed [21:0] lr_nxt;
  logic signed [19:0] a_nxt;
  always_comb begin
    em2 = $signed({1'b0, in_c.e}) - 6'sd2;
    if (in_c.zero) begin
      lr_nxt = 22'(dsc_pkg::LN_TENTH);
      a_nxt  = '0;
    end else begin
      lr_nxt = 22'(in_c.hz) + 22'(em2) * 22'sd22713;
      a_nxt  = in_c.cz;
    end
  end

  // rounded twist term in q16
  logic signed [54:0] tp;
  always_comb begin
    tp = 55'(ta_r) * 55'(dsc_pkg::PI_Q16) + (55'sd1 <<< 23);
  end

  // parity tests
  logic bu, bv;
  always_comb begin
    bu = u_r[47] || !u_r[24];
    bv = v_r[47] || !v_r[24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      lr1_r <= lr_nxt;
      a1_r  <= a_nxt;
      ta_r  <= 36'(cfg.spiral_tightness) * 36'(a_nxt);
    end
    if (rdy2 && v1_r) begin
      lr2_r <= lr1_r;
      a2_r  <= a1_r;
      p_r   <= 31'(tp >>> 24);
    end
    if (rdy3 && v2_r) begin
      u_r <= (48'(lr2_r) - 48'(p_r)) * 48'(cfg.repetitions);
      v_r <= 48'(a2_r) * 48'(cfg.repetitions);
    end
    if (rdy4 && v3_r) begin
      o_r.takes_first <= (bu != bv);
      o_r.pixel_color <= (bu != bv) ? cfg.first_color : cfg.second_color;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = o_r;

endmodule
`default_nettype wire

>>> rtl/droste_spiral_checker_pixel_unit.sv
// path: the prep stages, the row of cordic cells and the post stages, each stage registered
// throughput: one pixel per cycle while out_ready is high, set by the row of cordic cells,
// one micro-rotation pair each; a stalled output holds its result while empty stages upstream keep filling
// reset: synchronous active-low rst_n clears all valid flags and loads register
// defaults (640, 480, 0, 1.0, all ones, 0)
`default_nettype none
module droste_spiral_checker_pixel_unit #(
  parameter int COORD_BITS    = dsc_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = dsc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dsc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dsc_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  dsc_pkg::cfg_t cfg_r;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= 13'd640;
      cfg_r.image_height     <= 13'd480;
      cfg_r.spiral_tightness <= 16'sd0;
      cfg_r.repetitions      <= 16'sd256;
      cfg_r.first_color      <= '1;
      cfg_r.second_color     <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        dsc_pkg::REG_WIDTH:  cfg_r.image_width      <= pwdata[12:0];
        dsc_pkg::REG_HEIGHT: cfg_r.image_height     <= pwdata[12:0];
        dsc_pkg::REG_TIGHT:  cfg_r.spiral_tightness <= pwdata[15:0];
        dsc_pkg::REG_REPS:   cfg_r.repetitions      <= pwdata[15:0];
        dsc_pkg::REG_FIRST:  cfg_r.first_color      <= pwdata[47:0];
        dsc_pkg::REG_SECOND: cfg_r.second_color     <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      dsc_pkg::REG_WIDTH:  prdata = {51'b0, cfg_r.image_width};
      dsc_pkg::REG_HEIGHT: prdata = {51'b0, cfg_r.image_height};
      dsc_pkg::REG_TIGHT:  prdata = {48'b0, cfg_r.spiral_tightness};
      dsc_pkg::REG_REPS:   prdata = {48'b0, cfg_r.repetitions};
      dsc_pkg::REG_FIRST:  prdata = {16'b0, cfg_r.first_color};
      dsc_pkg::REG_SECOND: prdata = {16'b0, cfg_r.second_color};
      default:             prdata = '0;
    endcase
  end

  logic           cv  [CORDIC_STAGES+1];
  logic           cr  [CORDIC_STAGES+1];
  dsc_pkg::cord_t cc  [CORDIC_STAGES+1];

  // offsets, squares and normalisation
  dsc_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(cv[0]),
    .out_ready(cr[0]),
    .out_c    (cc[0])
  );

  // row of cordic cells
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    dsc_cell #(.K(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[k]),
      .in_ready (cr[k]),
      .in_c     (cc[k]),
      .out_valid(cv[k+1]),
      .out_ready(cr[k+1]),
      .out_c    (cc[k+1])
    );
  end

  // log, twist, parities and colour pick
  dsc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (cv[CORDIC_STAGES]),
    .in_ready (cr[CORDIC_STAGES]),
    .in_c     (cc[CORDIC_STAGES]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
